@@ hdl/nwws_pkg.sv @@
// ----------------------------------------------------------------------------
// nwws_pkg
// Shared types, constants and the arctangent table for the nearest waypoint
// window select core.
// ----------------------------------------------------------------------------
package nwws_pkg;

    localparam int MAX_WAYPOINTS = 1024;
    localparam int ADDR_W        = $clog2(MAX_WAYPOINTS);
    localparam int IDX_W         = 11;
    localparam int POS_W         = 32;
    localparam int ANG_W         = 16;
    localparam int CORDIC_STEPS  = 16;
    localparam int STEP_W        = $clog2(CORDIC_STEPS + 1);
    localparam int CW            = POS_W + 4;
    localparam int PHASE_W       = 32;
    localparam int WP_W          = 2 * POS_W + ANG_W;
    localparam int CFG_IDX_W     = 2;

    localparam logic signed [ANG_W:0] QUARTER_TURN   = 17'sd16384;
    localparam logic [ANG_W-1:0]      BEHIND_LO      = 16'd16384;
    localparam logic [ANG_W-1:0]      BEHIND_HI      = 16'd49152;
    localparam logic [PHASE_W-1:0]    HALF_TURN      = 32'h8000_0000;
    localparam logic [PHASE_W-1:0]    PHASE_ROUND    = 32'h0000_8000;

    localparam logic [IDX_W-1:0] PATH_LENGTH_RST   = 11'd0;
    localparam logic [IDX_W-1:0] POINTS_BEFORE_RST = 11'd10;
    localparam logic [IDX_W-1:0] POINTS_AFTER_RST  = 11'd90;
    localparam logic [IDX_W-1:0] LEN_CAP           = IDX_W'(MAX_WAYPOINTS);

    localparam logic [CFG_IDX_W-1:0] CFG_PATH_LENGTH   = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_POINTS_BEFORE = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_POINTS_AFTER  = 2'd2;

    localparam logic OP_LOAD  = 1'b0;
    localparam logic OP_QUERY = 1'b1;

    typedef struct packed {
        logic latch;
        logic ram_we;
        logic scan_en;
        logic cordic_init;
        logic cordic_step;
        logic load_out;
    } nwws_cmd_t;

    typedef struct packed {
        logic start_out;
        logic scan_last;
        logic busy;
        logic cordic_done;
    } nwws_status_t;

    function automatic logic [PHASE_W-1:0] atan_phase(input logic [STEP_W-1:0] i);
        logic [PHASE_W-1:0] r;
        case (i)
            5'd0:    r = 32'd536870912;
            5'd1:    r = 32'd316933406;
            5'd2:    r = 32'd167458907;
            5'd3:    r = 32'd85004756;
            5'd4:    r = 32'd42667331;
            5'd5:    r = 32'd21354465;
            5'd6:    r = 32'd10680862;
            5'd7:    r = 32'd5340245;
            5'd8:    r = 32'd2670163;
            5'd9:    r = 32'd1335087;
            5'd10:   r = 32'd667544;
            5'd11:   r = 32'd333772;
            5'd12:   r = 32'd166886;
            5'd13:   r = 32'd83443;
            5'd14:   r = 32'd41722;
            5'd15:   r = 32'd20861;
            5'd16:   r = 32'd10430;
            5'd17:   r = 32'd5215;
            5'd18:   r = 32'd2608;
            5'd19:   r = 32'd1304;
            5'd20:   r = 32'd652;
            5'd21:   r = 32'd326;
            5'd22:   r = 32'd163;
            5'd23:   r = 32'd81;
            default: r = '0;
        endcase
        return r;
    endfunction

endpackage

@@ hdl/nearest_waypoint_window_select_core.sv @@
// ----------------------------------------------------------------------------
// nearest_waypoint_window_select_core
// Stores a waypoint path and answers pose queries with the nearest
// heading-compatible waypoint, the next waypoint and a local window.
//
//   Channel  Direction  Handshake           Transaction
//   s_       in         s_valid / s_ready   waypoint load or pose query
//   m_       out        m_valid / m_ready   query result (none for loads)
//   cfg_     in         cfg_wr_en           register write, no wait
//
// A load is written straight into the store. In a query the scan reads one
// waypoint per cycle from the single read port of the store, then the
// bearing CORDIC runs one step per cycle. A query with start at or past the
// length skips the scan and the CORDIC. Reset is synchronous; the
// store has no clearing pass. A result waiting on m_ready holds the next
// query in its last cycle only; loads and new queries start meanwhile.
// ----------------------------------------------------------------------------
module nearest_waypoint_window_select_core (
    input  logic                                 aclk,
    input  logic                                 aresetn,
    input  logic                                 cfg_wr_en,
    input  logic [nwws_pkg::CFG_IDX_W-1:0]       cfg_index,
    input  logic [nwws_pkg::IDX_W-1:0]           cfg_wr_data,
    input  logic                                 s_valid,
    output logic                                 s_ready,
    input  logic                                 s_operation,
    input  logic [nwws_pkg::ADDR_W-1:0]          s_entry_index,
    input  logic signed [nwws_pkg::POS_W-1:0]    s_pos_x,
    input  logic signed [nwws_pkg::POS_W-1:0]    s_pos_y,
    input  logic signed [nwws_pkg::ANG_W-1:0]    s_heading,
    input  logic [nwws_pkg::IDX_W-1:0]           s_start_index,
    output logic                                 m_valid,
    input  logic                                 m_ready,
    output logic                                 m_valid_res,
    output logic [nwws_pkg::IDX_W-1:0]           m_closest_index,
    output logic [nwws_pkg::IDX_W-1:0]           m_next_index,
    output logic [nwws_pkg::IDX_W-1:0]           m_window_start,
    output logic [nwws_pkg::IDX_W-1:0]           m_window_end
);
    import nwws_pkg::*;

    nwws_cmd_t    cmd;
    nwws_status_t status;

    nwws_ctrl u_ctrl (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .s_valid     (s_valid),
        .s_ready     (s_ready),
        .s_operation (s_operation),
        .m_valid     (m_valid),
        .m_ready     (m_ready),
        .cmd         (cmd),
        .status      (status)
    );

    nwws_dp u_dp (
        .aclk            (aclk),
        .aresetn         (aresetn),
        .cmd             (cmd),
        .status          (status),
        .cfg_wr_en       (cfg_wr_en),
        .cfg_index       (cfg_index),
        .cfg_wr_data     (cfg_wr_data),
        .s_entry_index   (s_entry_index),
        .s_pos_x         (s_pos_x),
        .s_pos_y         (s_pos_y),
        .s_heading       (s_heading),
        .s_start_index   (s_start_index),
        .m_valid_res     (m_valid_res),
        .m_closest_index (m_closest_index),
        .m_next_index    (m_next_index),
        .m_window_start  (m_window_start),
        .m_window_end    (m_window_end)
    );

endmodule

@@ hdl/nwws_ram.sv @@
// ----------------------------------------------------------------------------
// nwws_ram
// Generic single-write, single-read RAM with registered read data.
// ----------------------------------------------------------------------------
module nwws_ram #(
    parameter int DATA_W = 8,
    parameter int DEPTH  = 16
) (
    input  logic                     aclk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [DATA_W-1:0]        wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [DATA_W-1:0]        rdata
);

    logic [DATA_W-1:0] mem [DEPTH];
    logic [DATA_W-1:0] rdata_reg;

    always_ff @(posedge aclk) begin
        if (we) begin
            mem[waddr] <= wdata;
        end
        rdata_reg <= mem[raddr];
    end

    assign rdata = rdata_reg;

endmodule

@@ hdl/nwws_dp.sv @@
// ----------------------------------------------------------------------------
// nwws_dp
// Datapath: configuration registers, waypoint store, distance scan pipeline,
// iterative CORDIC bearing and result registers.
// ----------------------------------------------------------------------------
module nwws_dp (
    input  logic                                 aclk,
    input  logic                                 aresetn,
    input  nwws_pkg::nwws_cmd_t                  cmd,
    output nwws_pkg::nwws_status_t               status,
    input  logic                                 cfg_wr_en,
    input  logic [nwws_pkg::CFG_IDX_W-1:0]       cfg_index,
    input  logic [nwws_pkg::IDX_W-1:0]           cfg_wr_data,
    input  logic [nwws_pkg::ADDR_W-1:0]          s_entry_index,
    input  logic signed [nwws_pkg::POS_W-1:0]    s_pos_x,
    input  logic signed [nwws_pkg::POS_W-1:0]    s_pos_y,
    input  logic signed [nwws_pkg::ANG_W-1:0]    s_heading,
    input  logic [nwws_pkg::IDX_W-1:0]           s_start_index,
    output logic                                 m_valid_res,
    output logic [nwws_pkg::IDX_W-1:0]           m_closest_index,
    output logic [nwws_pkg::IDX_W-1:0]           m_next_index,
    output logic [nwws_pkg::IDX_W-1:0]           m_window_start,
    output logic [nwws_pkg::IDX_W-1:0]           m_window_end
);
    import nwws_pkg::*;

    // configuration
    logic [IDX_W-1:0] path_length_reg, points_before_reg, points_after_reg;

    // query context
    logic signed [POS_W-1:0] px_reg, py_reg;
    logic signed [ANG_W-1:0] hd_reg;
    logic [IDX_W-1:0]        start_reg, len_reg, idx_reg;

    // store
    logic [WP_W-1:0] rdata;

    // scan pipeline
    logic                    rd_vld_reg;
    logic [IDX_W-1:0]        rd_idx_reg;
    logic                    s1_vld_reg, s1_gate_reg, s1_first_reg;
    logic [POS_W-1:0]        s1_ax_reg, s1_ay_reg;
    logic [IDX_W-1:0]        s1_idx_reg;
    logic signed [POS_W-1:0] s1_wx_reg, s1_wy_reg;
    logic                    s2_vld_reg, s2_gate_reg, s2_first_reg;
    logic [2*POS_W-1:0]      s2_sx_reg, s2_sy_reg;
    logic [IDX_W-1:0]        s2_idx_reg;
    logic signed [POS_W-1:0] s2_wx_reg, s2_wy_reg;
    logic                    s3_vld_reg, s3_gate_reg, s3_first_reg;
    logic [2*POS_W:0]        s3_sum_reg;
    logic [IDX_W-1:0]        s3_idx_reg;
    logic signed [POS_W-1:0] s3_wx_reg, s3_wy_reg;

    // best candidate
    logic                    found_reg;
    logic [2*POS_W:0]        best_reg;
    logic [IDX_W-1:0]        closest_reg;
    logic signed [POS_W-1:0] bx_reg, by_reg;

    // CORDIC
    logic signed [CW-1:0]    cx_reg, cy_reg;
    logic [PHASE_W-1:0]      cz_reg;
    logic [STEP_W-1:0]       step_reg;
    logic                    zero_reg;

    logic signed [POS_W:0]   s1_dx, s1_dy, s1_ndx, s1_ndy;
    logic signed [ANG_W:0]   s1_dh;
    logic signed [POS_W-1:0] rd_wx, rd_wy;
    logic signed [ANG_W-1:0] rd_wyaw;
    logic                    take;
    logic signed [POS_W:0]   c_dx, c_dy;
    logic signed [CW-1:0]    c_x0, c_y0, xs, ys;
    logic [PHASE_W-1:0]      zsum;
    logic [ANG_W-1:0]        bearing, hdiff;
    logic                    behind;
    logic [IDX_W-1:0]        next_idx, wstart, len_m1;
    logic [IDX_W:0]          wend_sum;

    // ---------------- store ----------------
    nwws_ram #(
        .DATA_W (WP_W),
        .DEPTH  (MAX_WAYPOINTS)
    ) u_store (
        .aclk  (aclk),
        .we    (cmd.ram_we),
        .waddr (s_entry_index),
        .wdata ({s_pos_x, s_pos_y, s_heading}),
        .raddr (idx_reg[ADDR_W-1:0]),
        .rdata (rdata)
    );

    assign rd_wx   = rdata[WP_W-1 -: POS_W];
    assign rd_wy   = rdata[ANG_W +: POS_W];
    assign rd_wyaw = rdata[ANG_W-1:0];

    // ---------------- configuration ----------------
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            path_length_reg   <= PATH_LENGTH_RST;
            points_before_reg <= POINTS_BEFORE_RST;
            points_after_reg  <= POINTS_AFTER_RST;
        end else if (cfg_wr_en) begin
            case (cfg_index)
                CFG_PATH_LENGTH:   path_length_reg   <= cfg_wr_data;
                CFG_POINTS_BEFORE: points_before_reg <= cfg_wr_data;
                CFG_POINTS_AFTER:  points_after_reg  <= cfg_wr_data;
                default: ;
            endcase
        end
    end

    // ---------------- query context and index ----------------
    always_ff @(posedge aclk) begin
        if (cmd.latch) begin
            px_reg    <= s_pos_x;
            py_reg    <= s_pos_y;
            hd_reg    <= s_heading;
            start_reg <= s_start_index;
            idx_reg   <= s_start_index;
            len_reg   <= (path_length_reg > LEN_CAP) ? LEN_CAP : path_length_reg;
        end else if (cmd.scan_en) begin
            idx_reg <= idx_reg + 1'b1;
        end
    end

    assign len_m1 = len_reg - 1'b1;

    // ---------------- scan pipeline ----------------
    assign s1_dx  = {px_reg[POS_W-1], px_reg} - {rd_wx[POS_W-1], rd_wx};
    assign s1_dy  = {py_reg[POS_W-1], py_reg} - {rd_wy[POS_W-1], rd_wy};
    assign s1_ndx = -s1_dx;
    assign s1_ndy = -s1_dy;
    assign s1_dh  = {hd_reg[ANG_W-1], hd_reg} - {rd_wyaw[ANG_W-1], rd_wyaw};

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            rd_vld_reg <= 1'b0;
            s1_vld_reg <= 1'b0;
            s2_vld_reg <= 1'b0;
            s3_vld_reg <= 1'b0;
        end else begin
            rd_vld_reg <= cmd.scan_en;
            s1_vld_reg <= rd_vld_reg;
            s2_vld_reg <= s1_vld_reg;
            s3_vld_reg <= s2_vld_reg;
        end
    end

    always_ff @(posedge aclk) begin
        rd_idx_reg   <= idx_reg;
        // stage 1: magnitudes and heading gate
        s1_ax_reg    <= s1_dx[POS_W] ? s1_ndx[POS_W-1:0] : s1_dx[POS_W-1:0];
        s1_ay_reg    <= s1_dy[POS_W] ? s1_ndy[POS_W-1:0] : s1_dy[POS_W-1:0];
        s1_gate_reg  <= (s1_dh >= -QUARTER_TURN) && (s1_dh <= QUARTER_TURN);
        s1_first_reg <= (rd_idx_reg == start_reg);
        s1_idx_reg   <= rd_idx_reg;
        s1_wx_reg    <= rd_wx;
        s1_wy_reg    <= rd_wy;
        // stage 2: squares
        s2_sx_reg    <= s1_ax_reg * s1_ax_reg;
        s2_sy_reg    <= s1_ay_reg * s1_ay_reg;
        s2_gate_reg  <= s1_gate_reg;
        s2_first_reg <= s1_first_reg;
        s2_idx_reg   <= s1_idx_reg;
        s2_wx_reg    <= s1_wx_reg;
        s2_wy_reg    <= s1_wy_reg;
        // stage 3: squared distance
        s3_sum_reg   <= {1'b0, s2_sx_reg} + {1'b0, s2_sy_reg};
        s3_gate_reg  <= s2_gate_reg;
        s3_first_reg <= s2_first_reg;
        s3_idx_reg   <= s2_idx_reg;
        s3_wx_reg    <= s2_wx_reg;
        s3_wy_reg    <= s2_wy_reg;
    end

    // later entry wins a tie
    assign take = s3_vld_reg && s3_gate_reg && (!found_reg || (s3_sum_reg <= best_reg));

    always_ff @(posedge aclk) begin
        if (cmd.latch) begin
            found_reg   <= 1'b0;
            closest_reg <= s_start_index;
        end else if (take) begin
            found_reg   <= 1'b1;
            best_reg    <= s3_sum_reg;
            closest_reg <= s3_idx_reg;
        end
        // start entry stands in when nothing qualifies
        if (take || (s3_vld_reg && s3_first_reg)) begin
            bx_reg <= s3_wx_reg;
            by_reg <= s3_wy_reg;
        end
    end

    // ---------------- CORDIC bearing ----------------
    assign c_dx = {bx_reg[POS_W-1], bx_reg} - {px_reg[POS_W-1], px_reg};
    assign c_dy = {by_reg[POS_W-1], by_reg} - {py_reg[POS_W-1], py_reg};
    assign c_x0 = CW'(c_dx);
    assign c_y0 = CW'(c_dy);
    assign xs   = cx_reg >>> step_reg;
    assign ys   = cy_reg >>> step_reg;

    always_ff @(posedge aclk) begin
        if (cmd.cordic_init) begin
            zero_reg <= (c_dx == '0) && (c_dy == '0);
            step_reg <= '0;
            if (c_dx[POS_W]) begin
                cx_reg <= -c_x0;
                cy_reg <= -c_y0;
                cz_reg <= HALF_TURN;
            end else begin
                cx_reg <= c_x0;
                cy_reg <= c_y0;
                cz_reg <= '0;
            end
        end else if (cmd.cordic_step) begin
            step_reg <= step_reg + 1'b1;
            if (!cy_reg[CW-1]) begin
                cx_reg <= cx_reg + ys;
                cy_reg <= cy_reg - xs;
                cz_reg <= cz_reg + atan_phase(step_reg);
            end else begin
                cx_reg <= cx_reg - ys;
                cy_reg <= cy_reg + xs;
                cz_reg <= cz_reg - atan_phase(step_reg);
            end
        end
    end

    // ---------------- result ----------------
    assign zsum     = cz_reg + PHASE_ROUND;
    assign bearing  = zero_reg ? '0 : zsum[PHASE_W-1 -: ANG_W];
    assign hdiff    = hd_reg - bearing;
    assign behind   = (hdiff > BEHIND_LO) && (hdiff < BEHIND_HI);
    assign next_idx = closest_reg + IDX_W'(behind);
    assign wstart   = (next_idx >= points_before_reg) ? (next_idx - points_before_reg) : '0;
    assign wend_sum = {1'b0, next_idx} + {1'b0, points_after_reg};

    always_ff @(posedge aclk) begin
        if (cmd.load_out) begin
            if (status.start_out) begin
                m_valid_res     <= 1'b0;
                m_closest_index <= start_reg;
                m_next_index    <= start_reg;
                m_window_start  <= '0;
                m_window_end    <= '0;
            end else begin
                m_valid_res     <= 1'b1;
                m_closest_index <= closest_reg;
                m_next_index    <= next_idx;
                m_window_start  <= wstart;
                m_window_end    <= (wend_sum > {1'b0, len_m1}) ? len_m1 : wend_sum[IDX_W-1:0];
            end
        end
    end

    // ---------------- status ----------------
    assign status.start_out   = (start_reg >= len_reg);
    assign status.scan_last   = (idx_reg == len_m1);
    assign status.busy        = rd_vld_reg | s1_vld_reg | s2_vld_reg | s3_vld_reg;
    assign status.cordic_done = (step_reg == STEP_W'(CORDIC_STEPS));

endmodule

@@ hdl/nwws_ctrl.sv @@
// ----------------------------------------------------------------------------
// nwws_ctrl
// Controller: sequences load, scan, drain, CORDIC and result hand-off.
// ----------------------------------------------------------------------------
module nwws_ctrl (
    input  logic                    aclk,
    input  logic                    aresetn,
    input  logic                    s_valid,
    output logic                    s_ready,
    input  logic                    s_operation,
    output logic                    m_valid,
    input  logic                    m_ready,
    output nwws_pkg::nwws_cmd_t     cmd,
    input  nwws_pkg::nwws_status_t  status
);
    import nwws_pkg::*;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_CHECK,
        ST_SCAN,
        ST_DRAIN,
        ST_CORDIC,
        ST_FINISH
    } state_t;

    state_t state_reg, state_next;
    logic   m_valid_reg, m_valid_next;
    logic   accept;

    assign s_ready = (state_reg == ST_IDLE);
    assign accept  = s_valid && s_ready;
    assign m_valid = m_valid_reg;

    always_comb begin
        cmd             = '0;
        cmd.latch       = accept && (s_operation == OP_QUERY);
        cmd.ram_we      = accept && (s_operation == OP_LOAD);
        cmd.scan_en     = (state_reg == ST_SCAN);
        cmd.cordic_init = (state_reg == ST_DRAIN) && !status.busy;
        cmd.cordic_step = (state_reg == ST_CORDIC) && !status.cordic_done;
        cmd.load_out    = (state_reg == ST_FINISH) && (!m_valid_reg || m_ready);
    end

    always_comb begin
        state_next = state_reg;
        case (state_reg)
            ST_IDLE:   if (cmd.latch) state_next = ST_CHECK;
            ST_CHECK:  state_next = status.start_out ? ST_FINISH : ST_SCAN;
            ST_SCAN:   if (status.scan_last) state_next = ST_DRAIN;
            ST_DRAIN:  if (!status.busy) state_next = ST_CORDIC;
            ST_CORDIC: if (status.cordic_done) state_next = ST_FINISH;
            ST_FINISH: if (cmd.load_out) state_next = ST_IDLE;
            default:   state_next = ST_IDLE;
        endcase
        m_valid_next = cmd.load_out ? 1'b1 : (m_ready ? 1'b0 : m_valid_reg);
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= ST_IDLE;
            m_valid_reg <= 1'b0;
        end else begin
            state_reg   <= state_next;
            m_valid_reg <= m_valid_next;
        end
    end

`ifndef SYNTHESIS
    a_load_needs_room: assert property (@(posedge aclk) disable iff (!aresetn)
        cmd.load_out |-> (!m_valid_reg || m_ready))
        else $error("result loaded over a pending transaction");

    a_last_scan_drains: assert property (@(posedge aclk) disable iff (!aresetn)
        (cmd.scan_en && status.scan_last) |=> (state_reg == ST_DRAIN && status.busy))
        else $error("scan end not followed by drain");

    a_cordic_after_drain: assert property (@(posedge aclk) disable iff (!aresetn)
        cmd.cordic_init |-> !status.busy)
        else $error("CORDIC started with scan in flight");

    a_query_checked: assert property (@(posedge aclk) disable iff (!aresetn)
        cmd.latch |=> (state_reg == ST_CHECK))
        else $error("query not followed by range check");
`endif

endmodule

@@ tb/tb_nearest_waypoint_window_select_core.sv @@
// ----------------------------------------------------------------------------
// tb_nearest_waypoint_window_select_core
// Loads waypoint paths and sends pose queries with random idling on both
// channels. Each result is compared field by field with a local model of the
// nearest-waypoint search, heading gate, bearing CORDIC and window clamp.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module tb_nearest_waypoint_window_select_core;
    import nwws_pkg::*;

    typedef struct packed {
        logic             valid_res;
        logic [IDX_W-1:0] closest;
        logic [IDX_W-1:0] next;
        logic [IDX_W-1:0] win_start;
        logic [IDX_W-1:0] win_end;
    } pose_result_t;

    typedef enum logic { ROW_ITEM, ROW_REG } row_kind_t;

    typedef struct {
        row_kind_t           kind;
        logic                op;
        logic [ADDR_W-1:0]   slot;
        logic signed [31:0]  x;
        logic signed [31:0]  y;
        logic signed [15:0]  hd;
        logic [IDX_W-1:0]    start;
        bit                  typed;
        pose_result_t        res;
        logic [CFG_IDX_W-1:0] reg_idx;
        logic [IDX_W-1:0]    reg_val;
    } stim_row_t;

    logic aclk, aresetn;
    logic cfg_wr_en;
    logic [CFG_IDX_W-1:0] cfg_index;
    logic [IDX_W-1:0] cfg_wr_data;
    logic s_valid, s_ready, s_operation;
    logic [ADDR_W-1:0] s_entry_index;
    logic signed [POS_W-1:0] s_pos_x, s_pos_y;
    logic signed [ANG_W-1:0] s_heading;
    logic [IDX_W-1:0] s_start_index;
    logic m_valid, m_ready, m_valid_res;
    logic [IDX_W-1:0] m_closest_index, m_next_index, m_window_start, m_window_end;

    nearest_waypoint_window_select_core DUT (.*);

    // model state
    logic signed [31:0] wp_x   [MAX_WAYPOINTS];
    logic signed [31:0] wp_y   [MAX_WAYPOINTS];
    logic signed [15:0] wp_yaw [MAX_WAYPOINTS];
    int unsigned path_len, pts_before, pts_after;

    pose_result_t pending_results[$];
    stim_row_t    dir_rows[$];
    int  fail_count = 0;
    int  src_idle_pct = 0, snk_idle_pct = 0;
    bit  hold_req = 0;
    int  hold_left = 0;
    int  rand_items = 0;

    initial begin
        aclk = 0;
        forever #5 aclk = ~aclk;
    end

    initial begin
        #20ms;
        $display("FAIL");
        $finish;
    end

    function automatic pose_result_t predict_pose(logic signed [31:0] px, logic signed [31:0] py,
                                                  logic signed [15:0] hd, logic [IDX_W-1:0] start);
        pose_result_t r;
        int unsigned len, closest, nxt, ws, we, mg;
        bit found;
        logic [66:0] ua, ub, sq_dist, best;
        longint ax, ay, dx, dy, xs, ys;
        logic [31:0] z;
        logic [31:0] zr;
        logic [15:0] brg, dd;
        int diff;
        len = path_len > MAX_WAYPOINTS ? MAX_WAYPOINTS : path_len;
        if (start >= len) begin
            r = '{1'b0, start, start, '0, '0};
            return r;
        end
        found = 0;
        best = '0;
        closest = start;
        for (int unsigned i = start; i < len; i++) begin
            ax = longint'(px) - longint'(wp_x[i]);
            ay = longint'(py) - longint'(wp_y[i]);
            ua = ax < 0 ? -ax : ax;
            ub = ay < 0 ? -ay : ay;
            sq_dist = ua * ua + ub * ub;
            diff = int'(hd) - int'(wp_yaw[i]);
            if (diff < 0) diff = -diff;
            // later waypoint wins a tie; gate uses unwrapped difference
            if ((!found || sq_dist <= best) && diff <= 16384) begin
                found = 1;
                best = sq_dist;
                closest = i;
            end
        end
        dx = longint'(wp_x[closest]) - longint'(px);
        dy = longint'(wp_y[closest]) - longint'(py);
        z = '0;
        if (dx == 0 && dy == 0) begin
            brg = '0;
        end else begin
            if (dx < 0) begin
                dx = -dx;
                dy = -dy;
                z = HALF_TURN;
            end
            for (int i = 0; i < CORDIC_STEPS; i++) begin
                xs = dx >>> i;
                ys = dy >>> i;
                if (dy >= 0) begin
                    dx = dx + ys;
                    dy = dy - xs;
                    z = z + atan_phase(STEP_W'(i));
                end else begin
                    dx = dx - ys;
                    dy = dy + xs;
                    z = z - atan_phase(STEP_W'(i));
                end
            end
            zr = z + PHASE_ROUND;
            brg = zr[31:16];
        end
        dd = hd - brg;
        mg = dd <= 32768 ? dd : 65536 - dd;
        nxt = closest + (mg > 16384 ? 1 : 0);
        ws = nxt >= pts_before ? nxt - pts_before : 0;
        we = nxt + pts_after;
        if (we > len - 1) we = len - 1;
        r = '{1'b1, IDX_W'(closest), IDX_W'(nxt), IDX_W'(ws), IDX_W'(we)};
        return r;
    endfunction

    function automatic logic signed [31:0] rand_coord();
        case ($urandom_range(0, 2))
            0:       return $urandom;
            1:       return $urandom_range(0, 1 << 20) - (1 << 19);
            default: return $urandom_range(0, 64) - 32;
        endcase
    endfunction

    task automatic send_item(logic op, logic [ADDR_W-1:0] slot, logic signed [31:0] x,
                             logic signed [31:0] y, logic signed [15:0] hd,
                             logic [IDX_W-1:0] start, bit typed, pose_result_t fixed);
        if ($urandom_range(0, 99) < src_idle_pct) begin
            s_valid <= 1'b0;
            repeat ($urandom_range(1, 4)) @(posedge aclk);
        end
        s_operation   <= op;
        s_entry_index <= slot;
        s_pos_x       <= x;
        s_pos_y       <= y;
        s_heading     <= hd;
        s_start_index <= start;
        s_valid       <= 1'b1;
        do @(posedge aclk); while (!s_ready);
        if (op == OP_LOAD) begin
            wp_x[slot]   = x;
            wp_y[slot]   = y;
            wp_yaw[slot] = hd;
        end else begin
            pending_results.insert(pending_results.size(),
                                   typed ? fixed : predict_pose(x, y, hd, start));
        end
    endtask

    // loads leave no result, so keep idling after the last one is taken
    task automatic wait_idle();
        s_valid <= 1'b0;
        wait (pending_results.size() == 0);
        repeat (12) @(posedge aclk);
    endtask

    task automatic write_reg(logic [CFG_IDX_W-1:0] idx, logic [IDX_W-1:0] val);
        @(posedge aclk);
        cfg_wr_en   <= 1'b1;
        cfg_index   <= idx;
        cfg_wr_data <= val;
        @(posedge aclk);
        cfg_wr_en <= 1'b0;
        case (idx)
            CFG_PATH_LENGTH:   path_len   = val;
            CFG_POINTS_BEFORE: pts_before = val;
            CFG_POINTS_AFTER:  pts_after  = val;
            default: ;
        endcase
    endtask

    task automatic add_item(logic op, logic [ADDR_W-1:0] slot, logic signed [31:0] x,
                            logic signed [31:0] y, logic signed [15:0] hd,
                            logic [IDX_W-1:0] start);
        stim_row_t r;
        r = '{ROW_ITEM, op, slot, x, y, hd, start, 1'b0, '0, '0, '0};
        dir_rows.insert(dir_rows.size(), r);
    endtask

    task automatic add_invalid(logic [IDX_W-1:0] start);
        stim_row_t r;
        r = '{ROW_ITEM, OP_QUERY, '0, 32'sd0, 32'sd0, 16'sd0, start, 1'b1,
              pose_result_t'{1'b0, start, start, '0, '0}, '0, '0};
        dir_rows.insert(dir_rows.size(), r);
    endtask

    task automatic add_reg(logic [CFG_IDX_W-1:0] idx, logic [IDX_W-1:0] val);
        stim_row_t r;
        r = '{ROW_REG, 1'b0, '0, 32'sd0, 32'sd0, 16'sd0, '0, 1'b0, '0, idx, val};
        dir_rows.insert(dir_rows.size(), r);
    endtask

    task automatic random_query(int unsigned len);
        logic [IDX_W-1:0] st;
        logic signed [31:0] x, y;
        logic signed [15:0] hd;
        int unsigned k;
        if (len > 0 && $urandom_range(0, 5) != 0)
            st = IDX_W'($urandom_range(0, len - 1));
        else
            st = IDX_W'($urandom_range(0, 2047));
        if (len > 0 && $urandom_range(0, 1)) begin
            k = $urandom_range(0, len - 1);
            x = wp_x[k] + $urandom_range(0, 1 << 17) - (1 << 16);
            y = wp_y[k] + $urandom_range(0, 1 << 17) - (1 << 16);
            hd = ANG_W'(wp_yaw[k] + $urandom_range(0, 40000) - 20000);
        end else begin
            x = rand_coord();
            y = rand_coord();
            hd = ANG_W'($urandom);
        end
        send_item(OP_QUERY, ADDR_W'($urandom), x, y, hd, st, 1'b0, '0);
    endtask

    // result side: check, then pick ready for the next edge
    initial begin
        pose_result_t e;
        m_ready = 1'b0;
        forever begin
            @(posedge aclk);
            if (aresetn && m_valid && m_ready) begin
                if (pending_results.size() == 0) begin
                    $error("result transaction with nothing expected");
                    fail_count++;
                end else begin
                    e = pending_results.pop_front();
                    if (m_valid_res !== e.valid_res) begin
                        $error("valid_res exp %0d got %0d", e.valid_res, m_valid_res);
                        fail_count++;
                    end
                    if (m_closest_index !== e.closest) begin
                        $error("closest_index exp %0d got %0d", e.closest, m_closest_index);
                        fail_count++;
                    end
                    if (m_next_index !== e.next) begin
                        $error("next_index exp %0d got %0d", e.next, m_next_index);
                        fail_count++;
                    end
                    if (m_window_start !== e.win_start) begin
                        $error("window_start exp %0d got %0d", e.win_start, m_window_start);
                        fail_count++;
                    end
                    if (m_window_end !== e.win_end) begin
                        $error("window_end exp %0d got %0d", e.win_end, m_window_end);
                        fail_count++;
                    end
                end
            end
            if (hold_req) begin
                hold_req = 0;
                hold_left = 400;
            end
            if (hold_left > 0) begin
                hold_left--;
                m_ready <= 1'b0;
            end else begin
                m_ready <= ($urandom_range(0, 99) >= snk_idle_pct);
            end
        end
    end

    initial begin
        int unsigned len, nq;
        aresetn = 1'b0;
        cfg_wr_en = 1'b0;
        cfg_index = '0;
        cfg_wr_data = '0;
        s_valid = 1'b0;
        s_operation = OP_LOAD;
        s_entry_index = '0;
        s_pos_x = '0;
        s_pos_y = '0;
        s_heading = '0;
        s_start_index = '0;
        path_len = PATH_LENGTH_RST;
        pts_before = POINTS_BEFORE_RST;
        pts_after = POINTS_AFTER_RST;
        repeat (3) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        // directed: empty path first, then a tiny path with extreme values
        src_idle_pct = 16;
        snk_idle_pct = 67;
        add_invalid(11'd0);
        add_invalid(11'd1024);
        add_invalid(11'd2047);
        add_item(OP_LOAD, 10'd0, 32'sd0, 32'sd0, 16'sd0, '0);
        add_item(OP_LOAD, 10'd1, 32'h7FFF_FFFF, 32'h8000_0000, 16'h7FFF, '0);
        add_item(OP_LOAD, 10'd2, 32'h8000_0000, 32'h7FFF_FFFF, 16'h8000, '0);
        add_item(OP_LOAD, 10'd3, 32'h0001_0000, 32'sd0, 16'sd0, 11'h7FF);
        add_item(OP_LOAD, 10'd1023, 32'hFFFF_FFFF, 32'h0000_0001, 16'h4000, '0);
        add_reg(CFG_PATH_LENGTH, 11'd4);
        add_reg(CFG_POINTS_BEFORE, 11'd0);
        add_reg(CFG_POINTS_AFTER, 11'd0);
        add_item(OP_QUERY, '0, 32'sd0, 32'sd0, 16'sd0, 11'd0);            // robot on waypoint
        add_item(OP_QUERY, '0, 32'h0002_0000, 32'sd0, 16'sd0, 11'd0);     // waypoint behind
        add_item(OP_QUERY, '0, 32'h8000_0000, 32'h8000_0000, 16'h7FFF, 11'd0);
        add_item(OP_QUERY, '0, 32'h7FFF_FFFF, 32'h7FFF_FFFF, 16'h8000, 11'd1);
        add_item(OP_QUERY, '0, 32'sd5, 32'sd5, 16'h4000, 11'd3);          // next past end
        add_invalid(11'd4);
        add_reg(CFG_POINTS_BEFORE, 11'd2047);
        add_reg(CFG_POINTS_AFTER, 11'd2047);
        add_item(OP_QUERY, '0, 32'sd0, 32'sd0, 16'hC000, 11'd2);
        foreach (dir_rows[i]) begin
            if (dir_rows[i].kind == ROW_REG) begin
                wait_idle();
                write_reg(dir_rows[i].reg_idx, dir_rows[i].reg_val);
            end else begin
                send_item(dir_rows[i].op, dir_rows[i].slot, dir_rows[i].x, dir_rows[i].y,
                          dir_rows[i].hd, dir_rows[i].start, dir_rows[i].typed,
                          dir_rows[i].res);
            end
        end

        // random phases: each loads a fresh path, then queries it
        for (int ph = 0; rand_items < 520; ph++) begin
            if (rand_items < 175) begin
                src_idle_pct = 16;
                snk_idle_pct = 67;
            end else if (rand_items < 350) begin
                src_idle_pct = 67;
                snk_idle_pct = 16;
            end else begin
                src_idle_pct = 0;
                snk_idle_pct = 0;
            end
            wait_idle();
            len = ($urandom_range(0, 9) == 0) ? 0 : $urandom_range(1, 40);
            write_reg(CFG_PATH_LENGTH, IDX_W'(len));
            write_reg(CFG_POINTS_BEFORE, IDX_W'($urandom_range(0, 3) == 0 ?
                                                $urandom_range(0, 2047) :
                                                $urandom_range(0, 20)));
            write_reg(CFG_POINTS_AFTER, IDX_W'($urandom_range(0, 3) == 0 ?
                                               $urandom_range(0, 2047) :
                                               $urandom_range(0, 20)));
            for (int unsigned i = 0; i < len; i++) begin
                // repeated positions now and then to exercise distance ties
                if (i > 0 && $urandom_range(0, 7) == 0)
                    send_item(OP_LOAD, ADDR_W'(i), wp_x[i-1], wp_y[i-1], ANG_W'($urandom),
                              '0, 1'b0, '0);
                else
                    send_item(OP_LOAD, ADDR_W'(i), rand_coord(), rand_coord(),
                              ANG_W'($urandom), IDX_W'($urandom), 1'b0, '0);
                rand_items++;
            end
            if (ph == 3) hold_req = 1;
            nq = (ph == 3) ? 20 : $urandom_range(6, 16);
            for (int q = 0; q < nq; q++) begin
                if ($urandom_range(0, 5) == 0)
                    send_item(OP_LOAD, ADDR_W'($urandom), rand_coord(), rand_coord(),
                              ANG_W'($urandom), IDX_W'($urandom), 1'b0, '0);
                else
                    random_query(len);
                rand_items++;
            end
        end

        // top of the store, length at and beyond capacity
        wait_idle();
        for (int i = MAX_WAYPOINTS - 24; i < MAX_WAYPOINTS; i++)
            send_item(OP_LOAD, ADDR_W'(i), rand_coord(), rand_coord(), ANG_W'($urandom),
                      '0, 1'b0, '0);
        wait_idle();
        write_reg(CFG_PATH_LENGTH, LEN_CAP);
        write_reg(CFG_POINTS_BEFORE, 11'd1024);
        write_reg(CFG_POINTS_AFTER, 11'd2047);
        send_item(OP_QUERY, '0, rand_coord(), rand_coord(), ANG_W'($urandom), 11'd1000,
                  1'b0, '0);
        send_item(OP_QUERY, '0, rand_coord(), rand_coord(), ANG_W'($urandom), 11'd1023,
                  1'b0, '0);
        send_item(OP_QUERY, '0, rand_coord(), rand_coord(), ANG_W'($urandom), 11'd1024,
                  1'b0, '0);
        wait_idle();
        write_reg(CFG_PATH_LENGTH, 11'd2047);
        send_item(OP_QUERY, '0, rand_coord(), rand_coord(), ANG_W'($urandom), 11'd1000,
                  1'b0, '0);
        send_item(OP_QUERY, '0, rand_coord(), rand_coord(), ANG_W'($urandom), 11'd2047,
                  1'b0, '0);

        wait_idle();
        repeat (50) @(posedge aclk);
        if (fail_count == 0)
            $display("PASS");
        else
            $display("FAIL");
        $finish;
    end

endmodule
